// File: rtl/core/bps_pkg.sv
// bps_pkg: shared widths, reset values and register indexes for the
// barometric pressure smoother. No dependencies.

package bps_pkg;

   // field widths
   localparam int RAW_W      = 18;
   localparam int SAMPLE_W   = 17;
   localparam int THR_W      = 16;
   localparam int GAIN_W     = 9;
   localparam int FRAC_W     = 8;
   localparam int ACC_W      = SAMPLE_W + FRAC_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int WINDOW_DEFAULT = 8;

   localparam logic [SAMPLE_W-1:0] PRESET_SAMPLE = 17'd100000;
   localparam logic [SAMPLE_W-1:0] OUT_MAX       = 17'd131071;
   localparam logic [ACC_W-1:0]    ACC_MAX       = {OUT_MAX, {FRAC_W{1'b0}}};
   localparam logic [ACC_W-1:0]    ACC_RESET     = {PRESET_SAMPLE, {FRAC_W{1'b0}}};
   localparam logic [GAIN_W-1:0]   GAIN_ONE      = 9'd256;

   localparam logic [THR_W-1:0]  THR_RESET       = 16'd100;
   localparam logic [GAIN_W-1:0] FAST_GAIN_RESET = 9'd72;
   localparam logic [GAIN_W-1:0] SLOW_GAIN_RESET = 9'd10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_GAIN      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_GAIN      = 2'd2;

endpackage

// File: rtl/core/bps_ifs.sv
// bps_ifs: valid/ready channel interfaces for sample requests, results and
// register writes. Depends on bps_pkg.

interface bps_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [bps_pkg::RAW_W-1:0]   raw_pressure;

   modport source (output valid, output raw_pressure, input ready);
   modport sink   (input valid, input raw_pressure, output ready);
endinterface

interface bps_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [bps_pkg::SAMPLE_W-1:0]       smooth_pressure;
   logic [bps_pkg::SAMPLE_W-1:0]       window_average;
   logic                               fast_used;

   modport source (output valid, output smooth_pressure, output window_average,
                   output fast_used, input ready);
   modport sink   (input valid, input smooth_pressure, input window_average,
                   input fast_used, output ready);
endinterface

interface bps_csr_if;
   logic                               valid;
   logic                               ready;
   logic [bps_pkg::CSR_IDX_W-1:0]      index;
   logic [bps_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/baro_pressure_smoother.sv
// baro_pressure_smoother: moving average plus two-speed exponential smoother
// for pressure samples. Depends on bps_pkg and the channel interfaces in bps_ifs.
//
// Usage:
//  - req_bus carries one signed sample (0.01 mbar) per request; negative
//    samples count as zero. rsp_bus returns one result per request: the
//    rounded smoothed pressure, the rounded window average and a flag that
//    says the fast gain was used.
//  - csr_bus writes jump_threshold (index 0), fast_gain (1), slow_gain (2);
//    other indexes are dropped. It is always ready; write it only while idle.
//  - Four-stage pipeline: input register, window-sum stage, average stage
//    (one reciprocal multiply), output register holding the smoother update.
//    An accepted request passes through these registers in order to rsp_bus.
//  - Throughput: one request per cycle while rsp_bus is ready. The bound is the
//    smoother loop in the last stage (one 10x26 multiply feeding the Q8 accumulator).
//  - Each stage has its own valid bit and ready term, so a stalled result
//    only holds the stages behind it once they are full; earlier bubbles
//    still fill.
//  - Reset (synchronous): ring entries read as 1000 mbar through per-entry
//    valid bits, sum and smoother preset to match, registers to defaults.

module baro_pressure_smoother #(
   parameter int WINDOW = bps_pkg::WINDOW_DEFAULT   // 2..64
) (
   input  logic      clock,
   input  logic      reset,
   bps_req_if.sink   req_bus,
   bps_rsp_if.source rsp_bus,
   bps_csr_if.sink   csr_bus
);
   import bps_pkg::*;

   // window arithmetic sizing
   localparam int PW   = $clog2(WINDOW);
   localparam int SUMW = $clog2(WINDOW * int'(OUT_MAX) + WINDOW / 2 + 1);
   localparam int SH   = SUMW + PW;
   localparam int MW   = SUMW + 1;
   localparam longint unsigned RECIP = ((64'd1 << SH) + WINDOW - 1) / WINDOW;
   localparam int AVW  = SUMW + MW - SH;
   localparam int PROD_W = GAIN_W + 1 + ACC_W + 1;

   localparam logic [PW-1:0]          POS_LAST  = PW'(WINDOW - 1);
   localparam logic [SUMW-1:0]        SUM_RESET = SUMW'(WINDOW * int'(PRESET_SAMPLE));
   localparam logic [SUMW-1:0]        HALF_WIN  = SUMW'(WINDOW / 2);
   localparam logic [MW-1:0]          RECIP_M   = RECIP[MW-1:0];
   localparam logic signed [PROD_W-1:0] ROUND_T = PROD_W'(1 << (FRAC_W - 1));

   // ---------------- configuration registers ----------------
   logic [THR_W-1:0]  thr_ff;
   logic [GAIN_W-1:0] fast_gain_ff;
   logic [GAIN_W-1:0] slow_gain_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THR_RESET;
         fast_gain_ff <= FAST_GAIN_RESET;
         slow_gain_ff <= SLOW_GAIN_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_JUMP_THRESHOLD: thr_ff       <= csr_bus.data;
            CSR_FAST_GAIN:      fast_gain_ff <= csr_bus.data[GAIN_W-1:0];
            CSR_SLOW_GAIN:      slow_gain_ff <= csr_bus.data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   logic take, mv12, mv23, mv34;

   assign rdy4 = !rsp_valid_ff || rsp_bus.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_bus.ready = rdy1;
   assign take = req_bus.valid && rdy1;
   assign mv12 = v1_ff && rdy2;
   assign mv23 = v2_ff && rdy3;
   assign mv34 = v3_ff && rdy4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= take || (v1_ff && !rdy2);
         v2_ff        <= mv12 || (v2_ff && !rdy3);
         v3_ff        <= mv23 || (v3_ff && !rdy4);
         rsp_valid_ff <= mv34 || (rsp_valid_ff && !rsp_bus.ready);
      end
   end

   // ---------------- stage 1: clamp negative samples ----------------
   logic [SAMPLE_W-1:0] sample_ff;

   always_ff @(posedge clock) begin
      if (take) begin
         sample_ff <= req_bus.raw_pressure[RAW_W-1] ? '0
                                                    : req_bus.raw_pressure[SAMPLE_W-1:0];
      end
   end

   // ---------------- stage 2: ring and running sum ----------------
   // rd_*_ff always holds the entry at pos_ff, prefetched as pos_ff advances.
   logic [SAMPLE_W-1:0] ring_mem [WINDOW];
   logic [WINDOW-1:0]   ring_vld_ff;
   logic [PW-1:0]       pos_ff;
   logic [PW-1:0]       pos_in;
   logic [PW-1:0]       rd_addr;
   logic [SAMPLE_W-1:0] rd_raw_ff;
   logic                rd_vld_ff;
   logic [SAMPLE_W-1:0] old_sample;
   logic [SUMW-1:0]     window_sum_ff;

   assign pos_in     = (pos_ff == POS_LAST) ? '0 : pos_ff + PW'(1);
   assign rd_addr    = mv12 ? pos_in : pos_ff;
   assign old_sample = rd_vld_ff ? rd_raw_ff : PRESET_SAMPLE;

   always_ff @(posedge clock) begin
      if (mv12) begin
         ring_mem[pos_ff] <= sample_ff;
      end
      rd_raw_ff <= ring_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         pos_ff        <= '0;
         window_sum_ff <= SUM_RESET;
      end else begin
         rd_vld_ff <= ring_vld_ff[rd_addr];
         if (mv12) begin
            ring_vld_ff[pos_ff] <= 1'b1;
            pos_ff              <= pos_in;
            window_sum_ff       <= window_sum_ff - SUMW'(old_sample) + SUMW'(sample_ff);
         end
      end
   end

   // ---------------- stage 3: rounded average by reciprocal ----------------
   logic [SUMW-1:0]    sum_rnd;
   logic [SUMW+MW-1:0] avg_prod;
   logic [AVW-1:0]     avg_wide;
   logic [SAMPLE_W-1:0] avg3_ff;

   assign sum_rnd  = window_sum_ff + HALF_WIN;
   assign avg_prod = (SUMW+MW)'(sum_rnd) * (SUMW+MW)'(RECIP_M);
   assign avg_wide = avg_prod[SUMW+MW-1:SH];

   always_ff @(posedge clock) begin
      if (mv23) begin
         avg3_ff <= (avg_wide > AVW'(OUT_MAX)) ? OUT_MAX : avg_wide[SAMPLE_W-1:0];
      end
   end

   // ---------------- stage 4: two-speed smoother and result ----------------
   logic [ACC_W-1:0]           acc_ff;
   logic signed [ACC_W:0]      diff;
   logic [ACC_W:0]             mag;
   logic                       fast;
   logic [GAIN_W-1:0]          gain_sel;
   logic [GAIN_W-1:0]          gain;
   logic signed [PROD_W-1:0]   prod;
   logic signed [PROD_W-1:0]   step;
   logic signed [PROD_W:0]     acc_sum;
   logic [ACC_W-1:0]           acc_in;
   logic [ACC_W:0]             acc_rnd;
   logic [SAMPLE_W:0]          smooth_wide;
   logic [SAMPLE_W-1:0]        smooth_ff;
   logic [SAMPLE_W-1:0]        avg_out_ff;
   logic                       fast_ff;

   always_comb begin
      diff     = $signed({1'b0, avg3_ff, {FRAC_W{1'b0}}}) - $signed({1'b0, acc_ff});
      mag      = diff[ACC_W] ? (~diff + (ACC_W+1)'(1)) : diff;
      fast     = mag > {2'b00, thr_ff, {FRAC_W{1'b0}}};
      gain_sel = fast ? fast_gain_ff : slow_gain_ff;
      gain     = (gain_sel > GAIN_ONE) ? GAIN_ONE : gain_sel;
      prod     = PROD_W'($signed({1'b0, gain})) * PROD_W'(diff);
      // floor((gain*diff + half) / 256)
      step     = (prod + ROUND_T) >>> FRAC_W;
      acc_sum  = $signed({{(PROD_W+1-ACC_W){1'b0}}, acc_ff}) + $signed({step[PROD_W-1], step});
      priority if (acc_sum[PROD_W]) begin
         acc_in = '0;
      end else if (acc_sum > $signed({{(PROD_W+1-ACC_W){1'b0}}, ACC_MAX})) begin
         acc_in = ACC_MAX;
      end else begin
         acc_in = acc_sum[ACC_W-1:0];
      end
      acc_rnd     = {1'b0, acc_in} + (ACC_W+1)'(ROUND_T);
      smooth_wide = acc_rnd[ACC_W:FRAC_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= ACC_RESET;
      end else if (mv34) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mv34) begin
         smooth_ff  <= (smooth_wide > (SAMPLE_W+1)'(OUT_MAX)) ? OUT_MAX
                                                              : smooth_wide[SAMPLE_W-1:0];
         avg_out_ff <= avg3_ff;
         fast_ff    <= fast;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.smooth_pressure = smooth_ff;
   assign rsp_bus.window_average  = avg_out_ff;
   assign rsp_bus.fast_used       = fast_ff;

`ifndef SYNTHESIS
   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      acc_ff <= ACC_MAX)
      else $error("smoother accumulator above its ceiling");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      window_sum_ff <= SUMW'(WINDOW * int'(OUT_MAX)))
      else $error("window sum above WINDOW full-scale samples");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("ring position past the window");

   a_out_tracks_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         smooth_ff == acc_ff[ACC_W-1:FRAC_W] + SAMPLE_W'(acc_ff[FRAC_W-1]))
      else $error("shown result does not match the smoother state");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      take |=> v1_ff)
      else $error("accepted request lost at the input stage");
`endif

endmodule

// File: dv/tb.sv
// tb: self-checking testbench for baro_pressure_smoother. A directed table
// is followed by random requests under random valid/ready idling.
// Depends on bps_pkg, the channel interfaces in bps_ifs and the block itself.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bps_pkg::*;

   localparam int WIN = WINDOW_DEFAULT;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;   // no register here
   localparam int RANDOM_PHASES    = 10;
   localparam int ITEMS_PER_PHASE  = 123;
   localparam int QUIET_PHASE      = 4;     // phase run with no idling at all
   localparam int DRAIN_CYCLES     = 20;    // pipeline is 4 deep; plenty of margin

   typedef struct packed {
      logic [SAMPLE_W-1:0] smooth_pressure;
      logic [SAMPLE_W-1:0] window_average;
      logic                fast_used;
   } smooth_result_type;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   // one row of the directed table: a sample request or a register write
   typedef struct packed {
      row_kind_type        kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [RAW_W-1:0]    value;     // raw sample, or write data in the low bits
      logic                has_exp;   // typed-in expectation instead of predictor
      smooth_result_type   exp;
   } stim_row_type;

   localparam int DIR_ROWS = 28;

   logic clock = 1'b0;
   logic reset;

   bps_req_if req_bus ();
   bps_rsp_if rsp_bus ();
   bps_csr_if csr_bus ();

   baro_pressure_smoother #(.WINDOW(WIN)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor state: register copies, window history and Q8 filter value
   // ---------------------------------------------------------------------
   logic [THR_W-1:0]    cfg_thr;
   logic [GAIN_W-1:0]   cfg_fast;
   logic [GAIN_W-1:0]   cfg_slow;
   logic [SAMPLE_W-1:0] hist [WIN];
   int unsigned         hist_pos;
   int unsigned         hist_sum;
   longint              filt_acc;

   smooth_result_type smoothed_q [$];   // results still owed by the block
   int             mismatch_cnt = 0;
   bit             no_idle = 1'b0;   // both sides run flat out while set
   int             level = 100000;   // drifting pressure level for random requests
   stim_row_type   dir_table [DIR_ROWS];

   function automatic void reset_predictor();
      cfg_thr  = THR_RESET;
      cfg_fast = FAST_GAIN_RESET;
      cfg_slow = SLOW_GAIN_RESET;
      for (int i = 0; i < WIN; i++) hist[i] = PRESET_SAMPLE;
      hist_pos = 0;
      hist_sum = WIN * PRESET_SAMPLE;
      filt_acc = longint'(ACC_RESET);
   endfunction

   function automatic void apply_reg_write(logic [CSR_IDX_W-1:0] idx,
                                           logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_JUMP_THRESHOLD: cfg_thr  = data;
         CSR_FAST_GAIN:      cfg_fast = data[GAIN_W-1:0];
         CSR_SLOW_GAIN:      cfg_slow = data[GAIN_W-1:0];
         default: ;   // unused index: write dropped
      endcase
   endfunction

   // One filter step: clamp, window update, two-speed Q8 smoothing.
   function automatic smooth_result_type smooth_step(logic [RAW_W-1:0] raw);
      smooth_result_type   r;
      logic [SAMPLE_W-1:0] sample;
      int unsigned         avg;
      int unsigned         gain;
      longint              diff;
      longint              mag;
      longint              prod;
      longint              acc;
      longint              outv;
      bit                  fast;
      sample = raw[RAW_W-1] ? '0 : raw[SAMPLE_W-1:0];
      hist_sum = hist_sum - hist[hist_pos] + sample;
      hist[hist_pos] = sample;
      hist_pos = (hist_pos + 1) % WIN;
      avg = (hist_sum + WIN / 2) / WIN;
      if (avg > OUT_MAX) avg = OUT_MAX;
      diff = longint'(avg) * 256 - filt_acc;
      mag  = (diff < 0) ? -diff : diff;
      fast = mag > longint'(cfg_thr) * 256;
      gain = fast ? cfg_fast : cfg_slow;
      if (gain > GAIN_ONE) gain = GAIN_ONE;
      prod = longint'(gain) * diff + 128;
      acc  = filt_acc + (prod >>> FRAC_W);   // arithmetic shift = floor
      if (acc < 0) acc = 0;
      if (acc > longint'(ACC_MAX)) acc = longint'(ACC_MAX);
      filt_acc = acc;
      outv = (acc + 128) >>> FRAC_W;
      if (outv > OUT_MAX) outv = OUT_MAX;
      r.smooth_pressure = outv[SAMPLE_W-1:0];
      r.window_average  = avg[SAMPLE_W-1:0];
      r.fast_used       = fast;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Offer one sample request, with random idle cycles in front. Valid stays
   // high after the accepting edge so back-to-back requests need no re-raise.
   task automatic send_sample(logic [RAW_W-1:0] raw, bit has_exp, smooth_result_type exp);
      smooth_result_type pred;
      while (!no_idle && $urandom_range(0, 99) < 36) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.raw_pressure <= raw;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pred = smooth_step(raw);   // keeps predictor state in step either way
      smoothed_q.push_back(has_exp ? exp : pred);
   endtask

   // Hold off new requests until every owed result has come back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (smoothed_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      apply_reg_write(idx, data);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'(GAIN_ONE);
         2:       return 16'd511;                      // saturates to 1.0
         3:       return 16'($urandom_range(0, 65535)); // upper bits masked off
         4:       return 16'($urandom_range(257, 511));
         default: return 16'($urandom_range(0, 256));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_threshold();
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, 2000));
      endcase
   endfunction

   // Mostly a slowly drifting level with sensor noise and rare steps; the rest
   // is negative samples, full-range noise and the field extremes.
   function automatic logic [RAW_W-1:0] next_sample();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         if ($urandom_range(0, 24) == 0) level = int'($urandom_range(0, 131071));
         else level = level + int'($urandom_range(0, 200)) - 100;
         if (level < 0) level = 0;
         if (level > 131071) level = 131071;
         v = level + int'($urandom_range(0, 60)) - 30;
         if (v > 131071) v = 131071;
      end else if (r < 80) begin
         v = -int'($urandom_range(1, 131072));
      end else if (r < 90) begin
         v = int'($urandom_range(0, 262143)) - 131072;
      end else begin
         case ($urandom_range(0, 3))
            0:       v = 131071;
            1:       v = -131072;
            2:       v = 0;
            default: v = -1;
         endcase
      end
      return RAW_W'(v);
   endfunction

   // ---------------------------------------------------------------------
   // Result side: random ready, in-order compare against owed results
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      smooth_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= 36);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (smoothed_q.size() == 0) begin
            $display("%0t unexpected result: smooth %0d avg %0d fast %0d", $time,
                     rsp_bus.smooth_pressure, rsp_bus.window_average, rsp_bus.fast_used);
            mismatch_cnt++;
         end else begin
            want = smoothed_q.pop_front();
            if (rsp_bus.smooth_pressure !== want.smooth_pressure) begin
               $display("%0t smooth_pressure: expected %0d, actual %0d", $time,
                        want.smooth_pressure, rsp_bus.smooth_pressure);
               mismatch_cnt++;
            end
            if (rsp_bus.window_average !== want.window_average) begin
               $display("%0t window_average: expected %0d, actual %0d", $time,
                        want.window_average, rsp_bus.window_average);
               mismatch_cnt++;
            end
            if (rsp_bus.fast_used !== want.fast_used) begin
               $display("%0t fast_used: expected %0d, actual %0d", $time,
                        want.fast_used, rsp_bus.fast_used);
               mismatch_cnt++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      smooth_result_type none;
      none = '0;

      // Directed table. The first two rows follow reset: the ring is full of
      // the preset, so a preset sample leaves everything still.
      dir_table = '{
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'd100000, 1'b1, '{17'd100000, 17'd100000, 1'b0}},
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'd100000, 1'b1, '{17'd100000, 17'd100000, 1'b0}},
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'd131071, 1'b0, '0},   // largest sample
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'h20000,  1'b0, '0},   // most negative: clamps
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'h3FFFF,  1'b0, '0},   // minus one: clamps
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'd0,      1'b0, '0},
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'd1,      1'b0, '0},
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'h15555,  1'b0, '0},
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'h2AAAA,  1'b0, '0},   // negative pattern
         // every step fast at full gain, then climb to the top of the range
         '{ROW_CSR,    CSR_JUMP_THRESHOLD, 18'd0,      1'b0, '0},
         '{ROW_CSR,    CSR_FAST_GAIN,      18'd256,    1'b0, '0},
         '{ROW_CSR,    CSR_SLOW_GAIN,      18'd511,    1'b0, '0},   // gain above one
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'd131071, 1'b0, '0},
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'd131071, 1'b0, '0},
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'd131071, 1'b0, '0},
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'd131071, 1'b0, '0},
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'd131071, 1'b0, '0},
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'd131071, 1'b0, '0},
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'd131071, 1'b0, '0},
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'd131071, 1'b0, '0},
         // widest threshold, frozen filter, and a dropped write
         '{ROW_CSR,    CSR_JUMP_THRESHOLD, 18'hFFFF,   1'b0, '0},
         '{ROW_CSR,    CSR_FAST_GAIN,      18'd0,      1'b0, '0},
         '{ROW_CSR,    CSR_SLOW_GAIN,      18'd0,      1'b0, '0},
         '{ROW_CSR,    CSR_UNUSED_IDX,     18'hFFFF,   1'b0, '0},
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'h20000,  1'b0, '0},
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'd0,      1'b0, '0},
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'd65535,  1'b0, '0},
         '{ROW_SAMPLE, CSR_JUMP_THRESHOLD, 18'd131071, 1'b0, '0}
      };

      // every input known from time zero
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.raw_pressure <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= '0;
      csr_bus.data         <= '0;
      reset_predictor();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_table[i].kind == ROW_CSR) begin
            // registers only change with the pipeline empty
            drain_results();
            write_reg(dir_table[i].idx, dir_table[i].value[CSR_DATA_W-1:0]);
         end else begin
            send_sample(dir_table[i].value, dir_table[i].has_exp, dir_table[i].exp);
         end
      end

      // Random phases. Each starts with the sender paused until every result
      // is back, then a fresh register setting; now and then the unused index
      // gets a write that must change nothing.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain_results();
         no_idle = (ph == QUIET_PHASE);
         if (ph == 0) begin
            write_reg(CSR_JUMP_THRESHOLD, THR_RESET);
            write_reg(CSR_FAST_GAIN, FAST_GAIN_RESET);
            write_reg(CSR_SLOW_GAIN, SLOW_GAIN_RESET);
         end else begin
            write_reg(CSR_JUMP_THRESHOLD, pick_threshold());
            write_reg(CSR_FAST_GAIN, pick_gain());
            write_reg(CSR_SLOW_GAIN, pick_gain());
            if ($urandom_range(0, 2) == 0)
               write_reg(CSR_UNUSED_IDX, 16'($urandom_range(0, 65535)));
         end
         level = int'($urandom_range(60000, 120000));
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_sample(next_sample(), 1'b0, none);
      end
      no_idle = 1'b0;

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0 && smoothed_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // hard stop, far above the slowest correct run
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: files.f
rtl/core/bps_pkg.sv
rtl/core/bps_ifs.sv
rtl/core/baro_pressure_smoother.sv
dv/tb.sv
